### rtl/sbfd_pkg.sv
// Shared constants and types for the SBUS frame decoder.
`timescale 1ns / 1ps
package sbfd_pkg;

	// Frame layout
	localparam int FRAME_BYTES     = 24;
	localparam int ANALOG_BYTES    = 22;
	localparam int ANALOG_CHANNELS = 16;
	localparam int FLAG_BYTE       = 22;
	localparam int CHAN_W          = 11;
	localparam int IDX_W           = 5;
	localparam int COUNT_W         = 5;

	// Flag byte bit positions
	localparam int DIG0_POS     = 0;
	localparam int DIG1_POS     = 1;
	localparam int LOST_POS     = 2;
	localparam int FAILSAFE_POS = 3;

	// Digital channel numbers
	localparam logic [IDX_W-1:0] DIG0_CHAN = 5'd16;
	localparam logic [IDX_W-1:0] DIG1_CHAN = 5'd17;

	// Header register reset value
	localparam logic [7:0] HEADER_RESET = 8'h0F;

	// Double-buffered frame store: one bank bit above the byte index
	localparam int BUF_AW    = COUNT_W + 1;
	localparam int BUF_DEPTH = 1 << BUF_AW;

	typedef logic [BUF_AW-1:0]  buf_addr_t;
	typedef logic [COUNT_W-1:0] byte_idx_t;

	// Completed frame handed to the queue
	typedef struct packed {
		logic valid;
		logic bank;
	} frame_push_t;

	// Bank given back once its frame is fully delivered
	typedef struct packed {
		logic valid;
		logic bank;
	} bank_rel_t;

	// Frame buffer write request
	typedef struct packed {
		logic      en;
		buf_addr_t addr;
		logic [7:0] data;
	} buf_wr_t;

	// Frame buffer read request
	typedef struct packed {
		logic      en;
		buf_addr_t addr;
	} buf_rd_t;

endpackage

### rtl/sbfd_if.sv
// Handshake interfaces for the SBUS frame decoder channels.
`timescale 1ns / 1ps
interface sbfd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface sbfd_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;

	modport source (output valid, output header_byte, input ready);
	modport sink (input valid, input header_byte, output ready);
endinterface

interface sbfd_chan_if;
	logic        valid;
	logic        ready;
	logic [4:0]  channel_index;
	logic [10:0] channel_value;
	logic        frame_lost;
	logic        failsafe_active;
	logic        last_of_frame;

	modport source (output valid, output channel_index, output channel_value,
		output frame_lost, output failsafe_active, output last_of_frame, input ready);
	modport sink (input valid, input channel_index, input channel_value,
		input frame_lost, input failsafe_active, input last_of_frame, output ready);
endinterface

### rtl/sbfd_frame_buf.sv
// Two-bank frame byte memory with one write and one registered read port.
`timescale 1ns / 1ps
module sbfd_frame_buf (
	input  logic             clk,
	input  sbfd_pkg::buf_wr_t wr,
	input  sbfd_pkg::buf_rd_t rd,
	output logic [7:0]       rd_data
);
	import sbfd_pkg::*;

	logic [7:0] mem_q [BUF_DEPTH];
	logic [7:0] rd_data_q;

	// Write a received byte, read one byte for the decoder
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem_q[rd.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

### rtl/sbfd_queue.sv
// Two-entry queue of completed frame banks between front and back.
`timescale 1ns / 1ps
module sbfd_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sbfd_pkg::frame_push_t push,
	output logic                  full,
	input  logic                  pop,
	output logic                  empty,
	output logic                  head_bank
);
	import sbfd_pkg::*;

	logic [1:0] entry_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push;
	logic       do_pop;

	assign full      = (fill_q == 2'd2);
	assign empty     = (fill_q == 2'd0);
	assign head_bank = entry_q[rd_ptr_q];
	assign do_push   = push.valid && !full;
	assign do_pop    = pop && !empty;

	// Store pushed bank numbers
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.bank;
		end
	end

	// Advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

### rtl/sbfd_front.sv
// Byte front end: header sync, byte counting and frame buffer writes.
`timescale 1ns / 1ps
module sbfd_front (
	input  logic                  clk,
	input  logic                  arst_n,
	sbfd_byte_if.sink             rx,
	sbfd_cfg_if.sink              cfg,
	input  logic                  q_full,
	input  sbfd_pkg::bank_rel_t   release_bank,
	output sbfd_pkg::frame_push_t push,
	output sbfd_pkg::buf_wr_t     wr
);
	import sbfd_pkg::*;

	logic [7:0] header_q;
	logic       synced_q;
	byte_idx_t  count_q;
	logic       wr_bank_q;
	logic [1:0] busy_q;
	logic [1:0] busy_next;
	byte_idx_t  count_inc;
	logic       accept;
	logic       hit;
	logic       frame_done;

	// Stall on a full queue, or while synced and the bank to fill holds a frame
	assign rx.ready  = !(synced_q && busy_q[wr_bank_q]) && !q_full;
	assign cfg.ready = 1'b1;

	always_comb begin
		accept     = rx.valid && rx.ready;
		hit        = (rx.rx_byte == header_q);
		count_inc  = count_q + byte_idx_t'(1);
		frame_done = synced_q && (count_inc == byte_idx_t'(FRAME_BYTES));

		wr.en   = accept && synced_q;
		wr.addr = {wr_bank_q, count_q};
		wr.data = rx.rx_byte;

		push.valid = accept && frame_done;
		push.bank  = wr_bank_q;

		// Mark a bank busy on frame hand-over, free it on release
		busy_next = busy_q;
		if (release_bank.valid) begin
			busy_next[release_bank.bank] = 1'b0;
		end
		if (push.valid) begin
			busy_next[wr_bank_q] = 1'b1;
		end
	end

	// Hold header register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= HEADER_RESET;
		end else if (cfg.valid && cfg.ready) begin
			header_q <= cfg.header_byte;
		end
	end

	// Track sync, byte position and bank ownership
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			synced_q  <= 1'b0;
			count_q   <= '0;
			wr_bank_q <= 1'b0;
			busy_q    <= 2'b00;
		end else begin
			busy_q <= busy_next;
			if (accept) begin
				if (frame_done) begin
					synced_q  <= 1'b0;
					count_q   <= '0;
					wr_bank_q <= ~wr_bank_q;
				end else begin
					synced_q <= synced_q || hit;
					if (synced_q) begin
						count_q <= count_inc;
					end
				end
			end
		end
	end

endmodule

### rtl/sbfd_back.sv
// Channel unpacker: streams a stored frame and emits its 18 channel results.
`timescale 1ns / 1ps
module sbfd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  logic                q_bank,
	output logic                q_pop,
	output sbfd_pkg::buf_rd_t   rd,
	input  logic [7:0]          rd_data,
	output sbfd_pkg::bank_rel_t release_bank,
	sbfd_chan_if.source         result
);
	import sbfd_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_FLAG_RD = 3'd1;
	localparam logic [2:0] ST_FLAG_LD = 3'd2;
	localparam logic [2:0] ST_FETCH   = 3'd3;
	localparam logic [2:0] ST_LOAD    = 3'd4;
	localparam logic [2:0] ST_EMIT    = 3'd5;
	localparam logic [2:0] ST_DIG0    = 3'd6;
	localparam logic [2:0] ST_DIG1    = 3'd7;

	localparam int RES_W  = CHAN_W + 7;
	localparam int NBIT_W = 5;

	logic [2:0]        state_q;
	logic              bank_q;
	logic [7:0]        flags_q;
	byte_idx_t         rd_idx_q;
	logic [RES_W-1:0]  res_q;
	logic [NBIT_W-1:0] nbits_q;
	logic [IDX_W-1:0]  chan_q;

	logic              out_valid_q;
	logic [IDX_W-1:0]  out_index_q;
	logic [CHAN_W-1:0] out_value_q;
	logic              out_lost_q;
	logic              out_fs_q;
	logic              out_last_q;

	logic              slot_free;
	logic              load_out;
	logic [IDX_W-1:0]  load_index;
	logic [CHAN_W-1:0] load_value;
	logic              load_last;
	logic [RES_W-1:0]  res_loaded;
	logic [NBIT_W-1:0] nbits_loaded;

	assign slot_free = !out_valid_q || result.ready;

	// Read port, queue pop, bank release and output load
	always_comb begin
		q_pop      = (state_q == ST_IDLE) && !q_empty;
		rd.en      = 1'b0;
		rd.addr    = {bank_q, rd_idx_q};
		load_out   = 1'b0;
		load_index = chan_q;
		load_value = res_q[CHAN_W-1:0];
		load_last  = 1'b0;
		release_bank.valid = 1'b0;
		release_bank.bank  = bank_q;

		res_loaded   = res_q | (RES_W'(rd_data) << nbits_q);
		nbits_loaded = nbits_q + NBIT_W'(8);

		unique case (state_q)
			ST_FLAG_RD: begin
				rd.en   = 1'b1;
				rd.addr = {bank_q, byte_idx_t'(FLAG_BYTE)};
			end
			ST_FETCH: begin
				rd.en = (rd_idx_q != byte_idx_t'(ANALOG_BYTES));
			end
			ST_EMIT: begin
				load_out = slot_free;
			end
			ST_DIG0: begin
				load_out   = slot_free;
				load_index = DIG0_CHAN;
				load_value = CHAN_W'(flags_q[DIG0_POS]);
			end
			ST_DIG1: begin
				load_out   = slot_free;
				load_index = DIG1_CHAN;
				load_value = CHAN_W'(flags_q[DIG1_POS]);
				load_last  = 1'b1;
				release_bank.valid = slot_free;
			end
			default: begin
			end
		endcase
	end

	// Sequence one frame: flags first, then bytes 0..21 through the bit reservoir
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_FLAG_RD;
					end
				end
				ST_FLAG_RD: state_q <= ST_FLAG_LD;
				ST_FLAG_LD: state_q <= ST_FETCH;
				ST_FETCH: begin
					if (rd_idx_q == byte_idx_t'(ANALOG_BYTES)) begin
						state_q <= ST_DIG0;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (nbits_loaded >= NBIT_W'(CHAN_W)) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_FETCH;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_FETCH;
					end
				end
				ST_DIG0: begin
					if (slot_free) begin
						state_q <= ST_DIG1;
					end
				end
				ST_DIG1: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working registers of the unpacker
	always_ff @(posedge clk) begin
		if (q_pop) begin
			bank_q <= q_bank;
		end
		if (state_q == ST_FLAG_LD) begin
			flags_q  <= rd_data;
			rd_idx_q <= '0;
			res_q    <= '0;
			nbits_q  <= '0;
			chan_q   <= '0;
		end
		if (state_q == ST_LOAD) begin
			res_q    <= res_loaded;
			nbits_q  <= nbits_loaded;
			rd_idx_q <= rd_idx_q + byte_idx_t'(1);
		end
		if ((state_q == ST_EMIT) && slot_free) begin
			res_q   <= res_q >> CHAN_W;
			nbits_q <= nbits_q - NBIT_W'(CHAN_W);
			chan_q  <= chan_q + IDX_W'(1);
		end
	end

	// Output register: hold until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_index_q <= load_index;
			out_value_q <= load_value;
			out_lost_q  <= flags_q[LOST_POS];
			out_fs_q    <= flags_q[FAILSAFE_POS];
			out_last_q  <= load_last;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.channel_index   = out_index_q;
	assign result.channel_value   = out_value_q;
	assign result.frame_lost      = out_lost_q;
	assign result.failsafe_active = out_fs_q;
	assign result.last_of_frame   = out_last_q;

endmodule

### rtl/sbus_frame_decoder.sv
// After a frame's last byte transfers, the frame is queued; the unpacker pops it, reads its
// flag byte, then fetches and loads stored bytes and registers each channel result.
// Throughput: one byte per cycle at the input, stalled while both frame banks hold undelivered
// frames; the unpacker reads stored bytes one at a time, alternating fetch and load states.
// Reset (arst_n, asynchronous, active low) clears sync, byte count, queue, unpacker and
// sets the header register to 0x0F; the frame buffer contents are not cleared.
`timescale 1ns / 1ps
module sbus_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	sbfd_cfg_if.sink    cfg,
	sbfd_byte_if.sink   rx,
	sbfd_chan_if.source result
);
	import sbfd_pkg::*;

	frame_push_t push;
	bank_rel_t   release_bank;
	buf_wr_t     wr;
	buf_rd_t     rd;
	logic [7:0]  rd_data;
	logic        q_full;
	logic        q_empty;
	logic        q_pop;
	logic        q_bank;

	sbfd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.rx           (rx),
		.cfg          (cfg),
		.q_full       (q_full),
		.release_bank (release_bank),
		.push         (push),
		.wr           (wr)
	);

	sbfd_frame_buf u_buf (
		.clk     (clk),
		.wr      (wr),
		.rd      (rd),
		.rd_data (rd_data)
	);

	sbfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (q_full),
		.pop       (q_pop),
		.empty     (q_empty),
		.head_bank (q_bank)
	);

	sbfd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_bank       (q_bank),
		.q_pop        (q_pop),
		.rd           (rd),
		.rd_data      (rd_data),
		.release_bank (release_bank),
		.result       (result)
	);

endmodule

### dv/testbench.sv
// Self-checking testbench for the SBUS frame decoder: predicts channel results per received byte.
`timescale 1ns / 1ps
module testbench;
	import sbfd_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int DRAIN_CYCLES = 80;
	localparam int PHASE_BYTES  = 36;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [CHAN_W-1:0] value;
		logic              lost;
		logic              failsafe;
		logic              last;
	} channel_t;

	// Frame predictor and store of expected channel results
	class frame_scoreboard;
		logic [7:0]  header;
		bit          synced;
		int unsigned count;
		logic [7:0]  frame[FRAME_BYTES];
		channel_t    pending[$];
		int          errors;

		function new();
			header = HEADER_RESET;
			synced = 1'b0;
			count  = 0;
			errors = 0;
		endfunction

		function void set_header(logic [7:0] v);
			header = v;
		endfunction

		// Advance the frame state by one byte
		function void note_byte(logic [7:0] b);
			logic [7:0]  flags;
			logic [23:0] word;
			int          bitpos;
			channel_t    c;
			if (synced && count < FRAME_BYTES) begin
				frame[count] = b;
				count++;
			end
			if (b == header)
				synced = 1'b1;
			if (count >= FRAME_BYTES) begin
				count  = 0;
				synced = 1'b0;
				flags  = frame[FLAG_BYTE];
				c.lost     = flags[LOST_POS];
				c.failsafe = flags[FAILSAFE_POS];
				c.last     = 1'b0;
				// Unpack the analog channels, eleven bits each, least significant first
				for (int ch = 0; ch < ANALOG_CHANNELS; ch++) begin
					bitpos  = ch * CHAN_W;
					word    = {frame[bitpos / 8 + 2], frame[bitpos / 8 + 1], frame[bitpos / 8]};
					c.index = IDX_W'(ch);
					c.value = CHAN_W'(word >> (bitpos % 8));
					pending.push_back(c);
				end
				c.index = DIG0_CHAN;
				c.value = CHAN_W'(flags[DIG0_POS]);
				pending.push_back(c);
				c.index = DIG1_CHAN;
				c.value = CHAN_W'(flags[DIG1_POS]);
				c.last  = 1'b1;
				pending.push_back(c);
			end
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			errors++;
		endtask

		// Compare one channel transfer with the oldest expectation
		task check_channel(channel_t got);
			channel_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected channel %0d value %0d", got.index, got.value));
				return;
			end
			want = pending.pop_front();
			if (got !== want)
				report($sformatf({"got idx %0d val %0d lost %b fs %b last %b, ",
					"want idx %0d val %0d lost %b fs %b last %b"},
					got.index, got.value, got.lost, got.failsafe, got.last,
					want.index, want.value, want.lost, want.failsafe, want.last));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	int          src_gap_pct;
	int          sink_stall_pct;
	int          phase_bytes;
	int unsigned cycles = 0;

	sbfd_cfg_if  cfg_if ();
	sbfd_byte_if rx_if ();
	sbfd_chan_if chan_if ();

	frame_scoreboard sb = new();

	sbus_frame_decoder u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_if),
		.rx     (rx_if),
		.result (chan_if)
	);

	always #6 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	// Stall the channel output at random
	always @(posedge clk) begin
		chan_if.ready <= (sink_stall_pct == 0) || ($urandom_range(99) >= sink_stall_pct);
	end

	// Score every channel transfer
	always @(posedge clk) begin
		if (arst_n && chan_if.valid && chan_if.ready)
			sb.check_channel(channel_t'{chan_if.channel_index, chan_if.channel_value,
				chan_if.frame_lost, chan_if.failsafe_active, chan_if.last_of_frame});
	end

	// Offer one byte, with random gaps in front, and hold it until it transfers
	task automatic send_byte(input logic [7:0] b);
		while (src_gap_pct != 0 && $urandom_range(99) < src_gap_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		sb.note_byte(b);
		phase_bytes++;
	endtask

	task automatic write_header(input logic [7:0] v);
		cfg_if.valid       <= 1'b1;
		cfg_if.header_byte <= v;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		cfg_if.valid <= 1'b0;
		sb.set_header(v);
	endtask

	// Drain all expected channels, then let any unfinished work settle
	task automatic wait_idle();
		rx_if.valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly whole frames with random content, the rest truncated frames and noise
	task automatic send_random_phase();
		int         kind;
		int         n;
		logic [7:0] b;
		phase_bytes = 0;
		while (phase_bytes < PHASE_BYTES) begin
			kind = $urandom_range(99);
			if (kind < 70) begin
				send_byte(sb.header);
				for (int i = 0; i < FRAME_BYTES; i++) begin
					b = 8'($urandom_range(255));
					if ($urandom_range(9) == 0)
						b = sb.header;
					send_byte(b);
				end
			end else if (kind < 85) begin
				send_byte(sb.header);
				n = $urandom_range(FRAME_BYTES - 1, 1);
				repeat (n) send_byte(8'($urandom_range(255)));
			end else begin
				n = $urandom_range(8, 1);
				repeat (n) send_byte(8'($urandom_range(255)));
			end
		end
	endtask

	initial begin
		logic [7:0] b;
		arst_n             <= 1'b0;
		rx_if.valid        <= 1'b0;
		rx_if.rx_byte      <= 8'h00;
		cfg_if.valid       <= 1'b0;
		cfg_if.header_byte <= 8'h00;
		src_gap_pct    = 0;
		sink_stall_pct = 0;
		phase_bytes    = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Noise while unsynced, then one frame of extremes with the header inside and at its end
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(sb.header);
		for (int i = 0; i < FRAME_BYTES; i++) begin
			if (i < 11)
				b = 8'hFF;
			else if (i == 15 || i == FRAME_BYTES - 1)
				b = sb.header;
			else if (i == FLAG_BYTE)
				b = 8'h0F;
			else
				b = 8'h00;
			send_byte(b);
		end
		// Sync has dropped, so this byte is ignored
		send_byte(8'hA5);
		send_random_phase();

		// Step through header settings and idling patterns
		for (int p = 1; p < 4; p++) begin
			wait_idle();
			case (p)
				1: begin
					src_gap_pct    = 56;
					sink_stall_pct = 0;
					write_header(8'h00);
				end
				2: begin
					src_gap_pct    = 0;
					sink_stall_pct = 56;
					write_header(8'hFF);
				end
				default: begin
					src_gap_pct    = 37;
					sink_stall_pct = 37;
					write_header(8'($urandom_range(255)));
				end
			endcase
			send_random_phase();
		end

		wait_idle();
		if (sb.errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### sbus_frame_decoder.f
rtl/sbfd_pkg.sv
rtl/sbfd_if.sv
rtl/sbfd_frame_buf.sv
rtl/sbfd_queue.sv
rtl/sbfd_front.sv
rtl/sbfd_back.sv
rtl/sbus_frame_decoder.sv
dv/testbench.sv
